// ----- hw/rtl/rpuf_pkg.sv -----
// Package for the rollback parity union-find unit.
// Holds the request and result types, the operation codes and default sizes.
// No dependencies.
package rpuf_pkg;

    localparam int VERTEX_W         = 10;
    localparam int DEPTH_W          = 11;
    localparam int DEFAULT_VERTICES = 1024;

    typedef enum logic [0:0] {
        OP_ADD_EDGE = 1'b0,
        OP_ROLLBACK = 1'b1
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic [VERTEX_W-1:0] vertex_a;
        logic [VERTEX_W-1:0] vertex_b;
        logic [DEPTH_W-1:0]  rollback_depth;
    } request_t;

    typedef struct packed {
        logic               odd_cycle;
        logic [DEPTH_W-1:0] undo_depth;
    } result_t;

endpackage

// ----- hw/rtl/rpuf_undo_stack.sv -----
// Undo stack of absorbed roots with its stack pointer.
// One synchronous memory; a pop returns the popped entry in the cycle after the pop.
// Depends on rpuf_pkg.
module rpuf_undo_stack #(
    parameter int VERTICES = rpuf_pkg::DEFAULT_VERTICES
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    input  logic [$clog2(2*VERTICES)-1:0]       push_node,
    input  logic                                pop,
    output logic [$clog2(2*VERTICES)-1:0]       pop_node,
    output logic [$clog2(2*VERTICES)-1:0]       depth
);
    import rpuf_pkg::*;

    localparam int NODES  = 2 * VERTICES;
    localparam int NODE_W = $clog2(NODES);

    logic [NODE_W-1:0] stack_mem [NODES];
    logic [NODE_W-1:0] depth_reg;
    logic [NODE_W-1:0] pop_node_reg;
    logic [NODE_W-1:0] pop_addr;

    assign pop_addr = depth_reg - NODE_W'(1);
    assign pop_node = pop_node_reg;
    assign depth    = depth_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= '0;
        end
        else if (push)
        begin
            depth_reg <= depth_reg + NODE_W'(1);
        end
        else if (pop)
        begin
            depth_reg <= pop_addr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            stack_mem[depth_reg] <= push_node;
        end
        pop_node_reg <= stack_mem[pop_addr];
    end

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> depth_reg != '0)
        else $error("undo stack popped while empty");

    a_no_push_and_pop: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !pop)
        else $error("undo stack pushed and popped together");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> 32'(depth_reg) < 32'(NODES - 1))
        else $error("undo stack overflow");

endmodule

// ----- hw/rtl/rollback_parity_union_find_unit.sv -----
// Top level of the rollback parity union-find unit.
// Holds the node memories (parent link, set size) and the sequencer.
// Depends on rpuf_pkg and rpuf_undo_stack.
//
// Usage:
//   request channel: valid/ready, one request_t per request. An add-edge request
//   joins vertex_a with the odd copy of vertex_b and the odd copy of vertex_a
//   with vertex_b; a rollback request pops joins down to rollback_depth.
//   result channel: valid/ready, one result_t per request, in order.
//   Requests are taken one at a time; request_ready is high only while idle.
//   Add edge: six root walks, each following the parent chain to its root, and
//   a join for each of the first two pairs whose roots differ; chains are at most
//   log2(2*VERTICES) links long under union by size. An add with a vertex out
//   of range goes straight to ST_DONE.
//   Rollback: each popped join passes through the check, node, top and sub
//   states. The single read port of the parent/size memories paces every walk
//   step and every pop. After reset the unit sweeps both node memories, one
//   node per cycle, before request_ready rises.
//   A finished result waits in the output register while the next request is
//   taken; if it is still not taken when the next result is ready, the
//   sequencer holds until result_ready.
module rollback_parity_union_find_unit #(
    parameter int VERTICES = rpuf_pkg::DEFAULT_VERTICES
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              request_valid,
    output logic              request_ready,
    input  rpuf_pkg::request_t request,
    output logic              result_valid,
    input  logic              result_ready,
    output rpuf_pkg::result_t  result
);
    import rpuf_pkg::*;

    localparam int NODES  = 2 * VERTICES;
    localparam int NODE_W = $clog2(NODES);
    localparam int SIZE_W = NODE_W + 1;

    localparam logic [1:0] PAIR_FIRST = 2'd0;
    localparam logic [1:0] PAIR_CHECK = 2'd2;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FIND_ISSUE,
        ST_FIND_WALK,
        ST_JOIN,
        ST_RB_CHECK,
        ST_RB_NODE,
        ST_RB_TOP,
        ST_RB_SUB,
        ST_DONE
    } state_t;

    state_t            state_reg;
    logic [NODE_W-1:0] clear_reg;
    op_t               op_reg;
    logic [NODE_W-1:0] a_node_reg;
    logic [NODE_W-1:0] b_node_reg;
    logic [DEPTH_W-1:0] target_reg;
    logic [1:0]        pair_reg;
    logic              half_reg;
    logic [NODE_W-1:0] walk_reg;
    logic [NODE_W-1:0] root_a_reg;
    logic [NODE_W-1:0] root_b_reg;
    logic [SIZE_W-1:0] size_a_reg;
    logic [SIZE_W-1:0] size_b_reg;
    logic [NODE_W-1:0] top_reg;
    logic              odd_reg;
    logic              result_valid_reg;
    result_t           result_reg;

    logic [NODE_W-1:0] parent_mem [NODES];
    logic [SIZE_W-1:0] size_mem [NODES];
    logic [NODE_W-1:0] parent_rdata_reg;
    logic [SIZE_W-1:0] size_rdata_reg;

    logic [NODE_W-1:0] rd_addr;
    logic              parent_we;
    logic [NODE_W-1:0] parent_wa;
    logic [NODE_W-1:0] parent_wd;
    logic              size_we;
    logic [NODE_W-1:0] size_wa;
    logic [SIZE_W-1:0] size_wd;

    logic [NODE_W-1:0] a_odd;
    logic [NODE_W-1:0] b_odd;
    logic [NODE_W-1:0] find_node;
    logic [NODE_W-1:0] small_root;
    logic [NODE_W-1:0] big_root;
    logic              in_range;
    logic              deeper;
    logic              out_free;

    logic              push;
    logic              pop;
    logic [NODE_W-1:0] pop_node;
    logic [NODE_W-1:0] depth;

    rpuf_undo_stack #(
        .VERTICES (VERTICES)
    ) u_undo_stack (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_node (small_root),
        .pop       (pop),
        .pop_node  (pop_node),
        .depth     (depth)
    );

    assign request_ready = (state_reg == ST_IDLE);
    assign result_valid  = result_valid_reg;
    assign result        = result_reg;

    assign a_odd    = a_node_reg + NODE_W'(VERTICES);
    assign b_odd    = b_node_reg + NODE_W'(VERTICES);
    assign in_range = (32'(request.vertex_a) < 32'(VERTICES))
                   && (32'(request.vertex_b) < 32'(VERTICES));
    assign deeper   = 32'(depth) > 32'(target_reg);
    assign out_free = !result_valid_reg || result_ready;

    assign small_root = (size_a_reg > size_b_reg) ? root_b_reg : root_a_reg;
    assign big_root   = (size_a_reg > size_b_reg) ? root_a_reg : root_b_reg;

    assign push = (state_reg == ST_JOIN);
    assign pop  = (state_reg == ST_RB_CHECK) && deeper;

    always_comb
    begin
        case (pair_reg)
            PAIR_FIRST: find_node = half_reg ? b_odd : a_node_reg;
            PAIR_CHECK: find_node = half_reg ? a_odd : a_node_reg;
            default:    find_node = half_reg ? b_node_reg : a_odd;
        endcase
    end

    always_comb
    begin
        case (state_reg)
            ST_FIND_ISSUE: rd_addr = find_node;
            ST_FIND_WALK:  rd_addr = parent_rdata_reg;
            ST_RB_NODE:    rd_addr = pop_node;
            ST_RB_TOP:     rd_addr = parent_rdata_reg;
            default:       rd_addr = walk_reg;
        endcase
    end

    always_comb
    begin
        parent_we = 1'b0;
        parent_wa = walk_reg;
        parent_wd = walk_reg;
        size_we   = 1'b0;
        size_wa   = top_reg;
        size_wd   = size_rdata_reg - size_a_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                parent_we = 1'b1;
                parent_wa = clear_reg;
                parent_wd = clear_reg;
                size_we   = 1'b1;
                size_wa   = clear_reg;
                size_wd   = SIZE_W'(1);
            end
            ST_JOIN:
            begin
                parent_we = 1'b1;
                parent_wa = small_root;
                parent_wd = big_root;
                size_we   = 1'b1;
                size_wa   = big_root;
                size_wd   = size_a_reg + size_b_reg;
            end
            ST_RB_TOP:
            begin
                parent_we = 1'b1;
            end
            ST_RB_SUB:
            begin
                size_we = 1'b1;
            end
            default:
            begin
                parent_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (parent_we)
        begin
            parent_mem[parent_wa] <= parent_wd;
        end
        if (size_we)
        begin
            size_mem[size_wa] <= size_wd;
        end
        parent_rdata_reg <= parent_mem[rd_addr];
        size_rdata_reg   <= size_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clear_reg        <= '0;
            op_reg           <= OP_ADD_EDGE;
            a_node_reg       <= '0;
            b_node_reg       <= '0;
            target_reg       <= '0;
            pair_reg         <= PAIR_FIRST;
            half_reg         <= 1'b0;
            walk_reg         <= '0;
            root_a_reg       <= '0;
            root_b_reg       <= '0;
            size_a_reg       <= '0;
            size_b_reg       <= '0;
            top_reg          <= '0;
            odd_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            if (result_valid_reg && result_ready && state_reg != ST_DONE)
            begin
                result_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR:
                begin
                    clear_reg <= clear_reg + NODE_W'(1);
                    if (clear_reg == NODE_W'(NODES - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (request_valid)
                    begin
                        op_reg     <= request.op;
                        a_node_reg <= NODE_W'(request.vertex_a);
                        b_node_reg <= NODE_W'(request.vertex_b);
                        target_reg <= request.rollback_depth;
                        odd_reg    <= 1'b0;
                        pair_reg   <= PAIR_FIRST;
                        half_reg   <= 1'b0;
                        if (request.op == OP_ROLLBACK)
                        begin
                            state_reg <= ST_RB_CHECK;
                        end
                        else if (in_range)
                        begin
                            state_reg <= ST_FIND_ISSUE;
                        end
                        else
                        begin
                            state_reg <= ST_DONE;
                        end
                    end
                end
                ST_FIND_ISSUE:
                begin
                    walk_reg  <= find_node;
                    state_reg <= ST_FIND_WALK;
                end
                ST_FIND_WALK:
                begin
                    if (parent_rdata_reg != walk_reg)
                    begin
                        walk_reg <= parent_rdata_reg;
                    end
                    else if (!half_reg)
                    begin
                        root_a_reg <= walk_reg;
                        size_a_reg <= size_rdata_reg;
                        half_reg   <= 1'b1;
                        state_reg  <= ST_FIND_ISSUE;
                    end
                    else
                    begin
                        root_b_reg <= walk_reg;
                        size_b_reg <= size_rdata_reg;
                        half_reg   <= 1'b0;
                        if (pair_reg == PAIR_CHECK)
                        begin
                            odd_reg   <= (walk_reg == root_a_reg);
                            state_reg <= ST_DONE;
                        end
                        else if (walk_reg != root_a_reg)
                        begin
                            state_reg <= ST_JOIN;
                        end
                        else
                        begin
                            pair_reg  <= pair_reg + 2'd1;
                            state_reg <= ST_FIND_ISSUE;
                        end
                    end
                end
                ST_JOIN:
                begin
                    pair_reg  <= pair_reg + 2'd1;
                    state_reg <= ST_FIND_ISSUE;
                end
                ST_RB_CHECK:
                begin
                    state_reg <= deeper ? ST_RB_NODE : ST_DONE;
                end
                ST_RB_NODE:
                begin
                    walk_reg  <= pop_node;
                    state_reg <= ST_RB_TOP;
                end
                ST_RB_TOP:
                begin
                    top_reg    <= parent_rdata_reg;
                    size_a_reg <= size_rdata_reg;
                    state_reg  <= ST_RB_SUB;
                end
                ST_RB_SUB:
                begin
                    state_reg <= ST_RB_CHECK;
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        result_valid_reg      <= 1'b1;
                        result_reg.odd_cycle  <= odd_reg;
                        result_reg.undo_depth <= DEPTH_W'(depth);
                        state_reg             <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_join_distinct_roots: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_JOIN |-> root_a_reg != root_b_reg)
        else $error("join of two nodes with the same root");

    a_join_pushes: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_JOIN |=> depth == $past(depth) + NODE_W'(1))
        else $error("join did not push the absorbed root");

    a_rollback_not_odd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && op_reg == OP_ROLLBACK) |-> !odd_reg)
        else $error("rollback result flags an odd cycle");

    a_no_result_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> !result_valid_reg && !request_ready)
        else $error("handshake active during memory sweep");

endmodule
